FILE: sv/mtis_pkg.sv
// ----------------------------------------------------------------------------
// mtis_pkg
// Shared types, address map and mode bit positions of the multi-timer block.
// ----------------------------------------------------------------------------
package mtis_pkg;

  localparam int unsigned NUM_TIMERS = 6;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [31:0] TMR_WIN_BASE = 32'h1000_1000;
  localparam logic [31:0] TMR_WIN_SIZE = 32'h0000_0100;
  localparam logic [31:0] TMR4_BASE    = 32'h1000_1400;
  localparam logic [31:0] TMR5_BASE    = 32'h1000_1800;
  localparam logic [31:0] STAT_ADDR    = 32'h1000_F000;
  localparam logic [31:0] MASK_ADDR    = 32'h1000_F010;

  localparam logic [7:0] OFF_COUNT  = 8'h00;
  localparam logic [7:0] OFF_MODE   = 8'h10;
  localparam logic [7:0] OFF_TARGET = 8'h20;

  localparam int unsigned BIT_ENABLE   = 0;
  localparam int unsigned BIT_TGT_MODE = 1;
  localparam int unsigned BIT_IRQ_EN   = 8;
  localparam int unsigned BIT_CLK_SEL  = 10;
  localparam int unsigned BIT_OVERFLOW = 14;
  localparam int unsigned STAT_LSB     = 16;

  localparam logic [1:0] CLK_DIV16  = 2'd0;
  localparam logic [1:0] CLK_DIV256 = 2'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [30:0] tick_cycles;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pending;
  } out_t;

  typedef struct packed {
    logic                  hit_stat;
    logic                  hit_mask;
    logic [NUM_TIMERS-1:0] tmr_sel;
    logic                  off_count;
    logic                  off_mode;
    logic                  off_target;
  } dec_t;

  typedef struct packed {
    logic        wr_count;
    logic        wr_mode;
    logic        wr_target;
    logic        tick;
    logic [31:0] wdata;
    logic [30:0] cycles;
  } tmr_ctrl_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] mode;
    logic [31:0] target;
  } tmr_state_t;

  function automatic logic [31:0] tmr_base(input int unsigned idx);
    logic [31:0] base;
    if (idx < 4) begin
      base = TMR_WIN_BASE + TMR_WIN_SIZE * 32'(idx);
    end else if (idx == 4) begin
      base = TMR4_BASE;
    end else begin
      base = TMR5_BASE;
    end
    return base;
  endfunction

endpackage

FILE: sv/mtis_decode.sv
// ----------------------------------------------------------------------------
// mtis_decode
// Address decode of a bus access onto status, mask and timer registers.
// ----------------------------------------------------------------------------
module mtis_decode (
  input  logic [31:0]  address,
  output mtis_pkg::dec_t dec
);
  import mtis_pkg::*;

  always_comb begin
    dec            = '0;
    dec.hit_stat   = (address == STAT_ADDR);
    dec.hit_mask   = (address == MASK_ADDR);
    for (int i = 0; i < NUM_TIMERS; i++) begin
      dec.tmr_sel[i] = ((address & 32'hFFFF_FF00) == tmr_base(i));
    end
    dec.off_count  = (address[7:0] == OFF_COUNT);
    dec.off_mode   = (address[7:0] == OFF_MODE);
    dec.off_target = (address[7:0] == OFF_TARGET);
  end

endmodule

FILE: sv/mtis_timer.sv
// ----------------------------------------------------------------------------
// mtis_timer
// One timer: count, mode and target registers with prescaled tick advance.
// ----------------------------------------------------------------------------
module mtis_timer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mtis_pkg::tmr_ctrl_t    ctrl,
  output mtis_pkg::tmr_state_t   st,
  output logic                   irq
);
  import mtis_pkg::*;

  logic [31:0] count_r, count_nxt;
  logic [31:0] mode_r, mode_nxt;
  logic [31:0] target_r, target_nxt;
  logic [30:0] inc;
  logic [32:0] sum;
  logic        ovf;

  always_comb begin
    unique case (mode_r[BIT_CLK_SEL +: 2])
      CLK_DIV16:  inc = ctrl.cycles >> 4;
      CLK_DIV256: inc = ctrl.cycles >> 8;
      default:    inc = ctrl.cycles;
    endcase
    if (inc == '0 && ctrl.cycles != '0) begin
      inc = 31'd1;
    end
    sum = {1'b0, count_r} + 33'(inc);
  end

  always_comb begin
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    target_nxt = target_r;
    ovf        = 1'b0;
    if (ctrl.tick && mode_r[BIT_ENABLE]) begin
      if (mode_r[BIT_TGT_MODE]) begin
        if (target_r != '0 && sum >= {1'b0, target_r}) begin
          count_nxt = '0;
          ovf       = 1'b1;
        end else begin
          count_nxt = sum[31:0];
        end
      end else begin
        ovf       = sum[32];
        count_nxt = sum[31:0];
      end
      if (ovf) begin
        mode_nxt[BIT_OVERFLOW] = 1'b1;
      end
    end
    if (ctrl.wr_count) begin
      count_nxt = '0;
    end
    if (ctrl.wr_mode) begin
      mode_nxt               = ctrl.wdata;
      mode_nxt[BIT_OVERFLOW] = mode_r[BIT_OVERFLOW];
      if (ctrl.wdata[BIT_ENABLE] && !mode_r[BIT_ENABLE]) begin
        count_nxt = '0;
      end
    end
    if (ctrl.wr_target) begin
      target_nxt = ctrl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      mode_r   <= '0;
      target_r <= '0;
    end else begin
      count_r  <= count_nxt;
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
    end
  end

  assign irq       = ovf && mode_r[BIT_IRQ_EN];
  assign st.count  = count_r;
  assign st.mode   = mode_r;
  assign st.target = target_r;

endmodule

FILE: sv/multi_timer_with_interrupt_status_core.sv
// ----------------------------------------------------------------------------
// multi_timer_with_interrupt_status_core
// Six timers with interrupt status and mask behind a bus/tick beat stream.
// ----------------------------------------------------------------------------
// A beat is held in the input register, its result in the result register.
// Throughput: one beat per cycle while the output is taken; the two registers
// decouple the two sides, and all timers update in parallel in one pass.
// Reset: synchronous active-low rst_n clears all timers, status, mask and
// both valid flags; the block is ready in the first cycle after reset.
module multi_timer_with_interrupt_status_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtis_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mtis_pkg::out_t  out_data
);
  import mtis_pkg::*;

  logic                  in_v_r, in_v_nxt;
  in_t                   in_r;
  logic                  out_v_r, out_v_nxt;
  out_t                  out_r;
  logic                  adv;
  dec_t                  dec;
  tmr_ctrl_t             ctrl [NUM_TIMERS];
  tmr_state_t            tst  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] tirq;
  logic [NUM_TIMERS-1:0] status_r, status_nxt;
  logic [31:0]           mask_r, mask_nxt;
  logic [31:0]           rd;
  logic                  is_rd, is_wr, is_tick;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  mtis_decode u_dec (
    .address (in_r.address),
    .dec     (dec)
  );

  always_comb begin
    is_rd   = 1'b0;
    is_wr   = 1'b0;
    is_tick = 1'b0;
    unique case (in_r.operation)
      OP_READ:  is_rd   = 1'b1;
      OP_WRITE: is_wr   = 1'b1;
      OP_TICK:  is_tick = 1'b1;
      default:  ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      ctrl[i].wr_count  = adv && is_wr && dec.tmr_sel[i] && dec.off_count;
      ctrl[i].wr_mode   = adv && is_wr && dec.tmr_sel[i] && dec.off_mode;
      ctrl[i].wr_target = adv && is_wr && dec.tmr_sel[i] && dec.off_target;
      ctrl[i].tick      = adv && is_tick;
      ctrl[i].wdata     = in_r.write_data;
      ctrl[i].cycles    = in_r.tick_cycles;
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
    mtis_timer u_tmr (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl[g]),
      .st    (tst[g]),
      .irq   (tirq[g])
    );
  end

  always_comb begin
    status_nxt = status_r;
    mask_nxt   = mask_r;
    if (adv && is_wr && dec.hit_stat) begin
      status_nxt = status_r & ~in_r.write_data[STAT_LSB +: NUM_TIMERS];
    end
    if (adv && is_wr && dec.hit_mask) begin
      mask_nxt = in_r.write_data;
    end
    if (adv && is_tick) begin
      status_nxt = status_r | tirq;
    end
  end

  always_comb begin
    rd = '0;
    if (is_rd) begin
      if (dec.hit_stat) begin
        rd[STAT_LSB +: NUM_TIMERS] = status_r;
      end
      if (dec.hit_mask) begin
        rd = mask_r;
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (dec.tmr_sel[i]) begin
          if (dec.off_count) begin
            rd = tst[i].count;
          end
          if (dec.off_mode) begin
            rd = tst[i].mode;
          end
          if (dec.off_target) begin
            rd = tst[i].target;
          end
        end
      end
    end
  end

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      status_r <= '0;
      mask_r   <= '0;
    end else begin
      in_v_r   <= in_v_nxt;
      out_v_r  <= out_v_nxt;
      status_r <= status_nxt;
      mask_r   <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r.read_data   <= rd;
      out_r.irq_pending <= |(status_nxt & mask_nxt[STAT_LSB +: NUM_TIMERS]);
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: sv/mtis_checker.sv
// ----------------------------------------------------------------------------
// mtis_checker
// Port-level checks of the multi-timer core, bound onto the top level.
// ----------------------------------------------------------------------------
module mtis_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input mtis_pkg::out_t out_data
);
  import mtis_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result beat two cycles after an accepted beat");

endmodule

bind multi_timer_with_interrupt_status_core mtis_checker u_mtis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
